FILE: rtl/core/tournament_branch_predictor_core_macros.svh
// Assertion macros used by the checker file.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Implication checked every clock, disabled during reset.
`define TBP_ASSERT_IMP(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked every clock, disabled during reset.
`define TBP_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/core/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared constants and a helper function of the tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int unsigned MaxBimodalBits = 12;
  localparam int unsigned MaxGshareBits  = 12;
  localparam int unsigned MaxChooserBits = 12;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgChooser = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGshare  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHistory = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBimodal = 2'd3;

  localparam logic [2:0] CtrInit  = 3'd4;
  localparam logic [2:0] CtrMax   = 3'd7;
  localparam logic [1:0] ChsInit  = 2'd1;
  localparam logic [1:0] ChsMax   = 2'd3;

  // Input item: tdata[31:0] branch_pc, tdata[32] taken.
  localparam int unsigned InDataW  = 40;
  // Result item: predicted_taken, mispredicted, chose_gshare, counts.
  localparam int unsigned OutDataW = 72;

  // Clamp a 4-bit width to the range 1..hi.
  function automatic logic [4:0] clamp_bits(input logic [3:0] v, input logic [4:0] hi);
    logic [4:0] r;
    r = {1'b0, v};
    if (r == 5'd0) r = 5'd1;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

FILE: rtl/core/tournament_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// Hybrid gshare/bimodal predictor trained by resolved branches.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata[31:0] branch_pc, tdata[32] taken
// m_axis    out  tdata: predicted_taken, mispredicted, chose_gshare, counts
// cfg       in   cfg_idx_i register index, cfg_data_i value
//
// Each item passes through a table read, the counter write-back that loads the
// output register, and the output handshake, since the next table read waits
// for an empty output register. After reset a clearing sweep over every table
// entry runs before the first item is taken from the queue.
// The front queue holds two items so input acceptance proceeds while the
// output register waits on m_axis_tready.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core #(
  parameter int unsigned MaxBimodalBits = tbp_pkg::MaxBimodalBits,
  parameter int unsigned MaxGshareBits  = tbp_pkg::MaxGshareBits,
  parameter int unsigned MaxChooserBits = tbp_pkg::MaxChooserBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] branch_pc, [32] taken
  input  logic [tbp_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] predicted_taken, [1] mispredicted, [2] chose_gshare,
  // [34:3] branch_count, [66:35] miss_count
  output logic [tbp_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [3:0]                    cfg_data_i
);
  import tbp_pkg::*;

  logic                      q_valid, q_pop, q_taken;
  logic [MaxBimodalBits-1:0] q_bi;
  logic [MaxGshareBits-1:0]  q_gpc, gmask;
  logic [MaxChooserBits-1:0] q_ci;
  logic [4:0]                hist_len;
  logic                      unused_pad;

  assign cfg_ready_o = 1'b1;
  assign unused_pad = ^s_axis_tdata[InDataW-1:33];

  tbp_front #(
    .BimodalBits(MaxBimodalBits), .GshareBits(MaxGshareBits), .ChooserBits(MaxChooserBits)
  ) u_front (
    .clk_i, .rst_ni,
    .pc_i(s_axis_tdata[31:0]), .taken_i(s_axis_tdata[32]),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .gmask_o(gmask), .hist_len_o(hist_len),
    .cfg_valid_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop),
    .q_bi_o(q_bi), .q_gpc_o(q_gpc), .q_ci_o(q_ci), .q_taken_o(q_taken)
  );

  tbp_back #(
    .BimodalBits(MaxBimodalBits), .GshareBits(MaxGshareBits), .ChooserBits(MaxChooserBits)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_bi_i(q_bi), .q_gpc_i(q_gpc), .q_ci_i(q_ci), .q_taken_i(q_taken),
    .hist_len_i(hist_len), .gmask_i(gmask),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );
endmodule

FILE: rtl/core/tbp_front.sv
// ----------------------------------------------------------------------------
// tbp_front
// Accepts branch items and classifies each into table indexes; holds the
// configuration registers and a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module tbp_front #(
  parameter int unsigned BimodalBits = tbp_pkg::MaxBimodalBits,
  parameter int unsigned GshareBits  = tbp_pkg::MaxGshareBits,
  parameter int unsigned ChooserBits = tbp_pkg::MaxChooserBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [31:0]                  pc_i,
  input  logic                         taken_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic [GshareBits-1:0]        gmask_o,
  output logic [4:0]                   hist_len_o,
  input  logic                         cfg_valid_i,
  input  logic [tbp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [3:0]                   cfg_data_i,
  output logic                         q_valid_o,
  input  logic                         q_pop_i,
  output logic [BimodalBits-1:0]       q_bi_o,
  output logic [GshareBits-1:0]        q_gpc_o,
  output logic [ChooserBits-1:0]       q_ci_o,
  output logic                         q_taken_o
);
  import tbp_pkg::*;

  logic [3:0] kbits_q, gbits_q, hbits_q, bbits_q;
  logic [4:0] kb, gb, bb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kbits_q <= 4'd8;
      gbits_q <= 4'd10;
      hbits_q <= 4'd6;
      bbits_q <= 4'd10;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        CfgChooser: kbits_q <= cfg_data_i;
        CfgGshare:  gbits_q <= cfg_data_i;
        CfgHistory: hbits_q <= cfg_data_i;
        CfgBimodal: bbits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign kb = clamp_bits(kbits_q, 5'(ChooserBits));
  assign gb = clamp_bits(gbits_q, 5'(GshareBits));
  assign bb = clamp_bits(bbits_q, 5'(BimodalBits));
  assign hist_len_o = clamp_bits(hbits_q, gb);

  // The gshare PC part is stored; history is XORed in the back end, where
  // the history of the item just before is final.
  logic [BimodalBits-1:0] bi;
  logic [GshareBits-1:0]  gpc;
  logic [ChooserBits-1:0] ci;
  logic [BimodalBits-1:0] bmask;
  logic [GshareBits-1:0]  gmask;
  logic [ChooserBits-1:0] cmask;

  always_comb begin
    bmask = '0;
    gmask = '0;
    cmask = '0;
    for (int i = 0; i < BimodalBits; i++) bmask[i] = (i < int'(bb));
    for (int i = 0; i < GshareBits; i++)  gmask[i] = (i < int'(gb));
    for (int i = 0; i < ChooserBits; i++) cmask[i] = (i < int'(kb));
    bi  = pc_i[2 +: BimodalBits] & bmask;
    gpc = pc_i[2 +: GshareBits] & gmask;
    ci  = pc_i[2 +: ChooserBits] & cmask;
  end

  // The history may still be longer than a newly narrowed gshare index.
  assign gmask_o = gmask;

  // Two-entry queue.
  localparam int unsigned EntW = BimodalBits + GshareBits + ChooserBits + 1;
  logic [EntW-1:0] ent_q [2];
  logic            rd_q, wr_q;
  logic [1:0]      cnt_q;
  logic            push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign {q_bi_o, q_gpc_o, q_ci_o, q_taken_o} = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= {bi, gpc, ci, taken_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

FILE: rtl/core/tbp_back.sv
// ----------------------------------------------------------------------------
// tbp_back
// Reads the three counter tables, forms the prediction, trains, and holds
// the result in an output register. Tables are cleared by a sweep after
// reset.
// ----------------------------------------------------------------------------
module tbp_back #(
  parameter int unsigned BimodalBits = tbp_pkg::MaxBimodalBits,
  parameter int unsigned GshareBits  = tbp_pkg::MaxGshareBits,
  parameter int unsigned ChooserBits = tbp_pkg::MaxChooserBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  logic [BimodalBits-1:0] q_bi_i,
  input  logic [GshareBits-1:0]  q_gpc_i,
  input  logic [ChooserBits-1:0] q_ci_i,
  input  logic                   q_taken_i,
  input  logic [4:0]             hist_len_i,
  input  logic [GshareBits-1:0]  gmask_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [tbp_pkg::OutDataW-1:0] out_data_o
);
  import tbp_pkg::*;

  localparam int unsigned MaxW = (BimodalBits > GshareBits) ?
      ((BimodalBits > ChooserBits) ? BimodalBits : ChooserBits) :
      ((GshareBits > ChooserBits) ? GshareBits : ChooserBits);

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StRead  = 3'b010,
    StWrite = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [MaxW:0] clr_q;

  logic [2:0] bim_mem [2**BimodalBits];
  logic [2:0] gsh_mem [2**GshareBits];
  logic [1:0] chs_mem [2**ChooserBits];
  logic [2:0] bim_rd_q, gsh_rd_q;
  logic [1:0] chs_rd_q;

  logic [GshareBits-1:0]  ghist_q;
  logic [GshareBits-1:0]  gi_q;
  logic [BimodalBits-1:0] bi_q;
  logic [ChooserBits-1:0] ci_q;
  logic                   tk_q;
  logic [31:0]            nbr_q, nmiss_q;
  logic                   ov_q;
  logic [2:0]             res_q;

  logic [GshareBits-1:0]  gi;
  assign gi = (q_gpc_i ^ ghist_q) & gmask_i;

  // An item is taken from the queue only once the output register is empty.
  logic out_free;
  assign out_free = !ov_q || out_ready_i;
  assign q_pop_o = (state_q == StRead) && q_valid_i && !ov_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q[MaxW]) state_d = StRead;
      StRead:  if (q_pop_o) state_d = StWrite;
      StWrite: if (out_free) state_d = StRead;
      default: state_d = StClear;
    endcase
  end

  // Prediction and training from the registered table reads.
  logic gpred, bpred, use_g, pred, miss;
  logic [2:0] ctr, ctr_n;
  logic [1:0] chs_n;
  assign gpred = gsh_rd_q >= CtrInit;
  assign bpred = bim_rd_q >= CtrInit;
  assign use_g = chs_rd_q >= 2'd2;
  assign pred  = use_g ? gpred : bpred;
  assign miss  = pred != tk_q;
  assign ctr   = use_g ? gsh_rd_q : bim_rd_q;

  always_comb begin
    if (tk_q) ctr_n = (ctr == CtrMax) ? ctr : ctr + 3'd1;
    else      ctr_n = (ctr == 3'd0) ? ctr : ctr - 3'd1;
    chs_n = chs_rd_q;
    if (gpred == tk_q && bpred != tk_q && chs_rd_q != ChsMax) chs_n = chs_rd_q + 2'd1;
    else if (gpred != tk_q && bpred == tk_q && chs_rd_q != 2'd0) chs_n = chs_rd_q - 2'd1;
  end

  logic wr_en;
  assign wr_en = (state_q == StWrite) && out_free;

  // History update: shift right, mask to length-1, outcome at top.
  logic [GshareBits-1:0] hist_n;
  always_comb begin
    for (int i = 0; i < GshareBits; i++) begin
      if (i == int'(hist_len_i) - 1) hist_n[i] = tk_q;
      else if (i < int'(hist_len_i) - 1 && i + 1 < GshareBits) hist_n[i] = ghist_q[i+1];
      else hist_n[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      bim_mem[clr_q[BimodalBits-1:0]] <= CtrInit;
      gsh_mem[clr_q[GshareBits-1:0]]  <= CtrInit;
      chs_mem[clr_q[ChooserBits-1:0]] <= ChsInit;
    end else if (wr_en) begin
      if (use_g) gsh_mem[gi_q] <= ctr_n;
      else       bim_mem[bi_q] <= ctr_n;
      chs_mem[ci_q] <= chs_n;
    end
    if (q_pop_o) begin
      bim_rd_q <= bim_mem[q_bi_i];
      gsh_rd_q <= gsh_mem[gi];
      chs_rd_q <= chs_mem[q_ci_i];
      bi_q <= q_bi_i;
      gi_q <= gi;
      ci_q <= q_ci_i;
      tk_q <= q_taken_i;
    end
    if (wr_en) res_q <= {use_g, miss, pred};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      ghist_q <= '0;
      nbr_q   <= '0;
      nmiss_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (wr_en) begin
        ghist_q <= hist_n;
        nbr_q   <= nbr_q + 32'd1;
        nmiss_q <= nmiss_q + 32'(miss);
        ov_q    <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {5'd0, nmiss_q, nbr_q, res_q};
endmodule

FILE: rtl/core/tbp_checker.sv
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the predictor's result stream.
// ----------------------------------------------------------------------------
`include "tournament_branch_predictor_core_macros.svh"

module tbp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tbp_pkg::OutDataW-1:0]  m_axis_tdata
);
  `TBP_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `TBP_ASSERT_IMP(a_miss, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[66:35] <= m_axis_tdata[34:3], "miss count above branch count")
  `TBP_ASSERT_NEXT(a_cnt, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid || m_axis_tdata[34:3] == $past(m_axis_tdata[34:3]) + 32'd1, "branch count not sequential")
  `TBP_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[71:67] == 5'd0, "pad bits set")
endmodule

bind tournament_branch_predictor_core tbp_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

FILE: sim/tournament_branch_predictor_core_tb.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor core testbench
// Streams resolved branches through the core under several table and history
// widths, predicts every result with a software copy of the three tables, and
// compares each result item field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core_tb;
  import tbp_pkg::*;

  typedef struct packed {
    logic [31:0] miss_count;
    logic [31:0] branch_count;
    logic        chose_gshare;
    logic        mispredicted;
    logic        predicted_taken;
  } outcome_t;

  class branch_scoreboard;
    logic [2:0]  bim_ctr [4096];
    logic [2:0]  gsh_ctr [4096];
    logic [1:0]  chs_ctr [4096];
    logic [11:0] ghist;
    logic [31:0] n_branch, n_miss;
    logic [3:0]  width_reg [4];
    outcome_t    pending [$];
    int          errors;

    function void clear();
      for (int i = 0; i < 4096; i++) begin
        bim_ctr[i] = CtrInit;
        gsh_ctr[i] = CtrInit;
        chs_ctr[i] = ChsInit;
      end
      ghist = '0;
      n_branch = '0;
      n_miss = '0;
      width_reg[CfgChooser] = 4'd8;
      width_reg[CfgGshare]  = 4'd10;
      width_reg[CfgHistory] = 4'd6;
      width_reg[CfgBimodal] = 4'd10;
      errors = 0;
    endfunction

    function int clampw(logic [3:0] v, int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // Predicts one result from the branch, then trains the copied tables.
    function void note_branch(logic [31:0] pc, logic tk);
      int kb, gb, bb, hb;
      logic [11:0] gi, bi, ci;
      logic gp, bp, ug, pr;
      outcome_t o;
      kb = clampw(width_reg[CfgChooser], MaxChooserBits);
      gb = clampw(width_reg[CfgGshare], MaxGshareBits);
      bb = clampw(width_reg[CfgBimodal], MaxBimodalBits);
      hb = clampw(width_reg[CfgHistory], gb);
      gi = ((pc[13:2] ^ ghist) & ((12'd1 << gb) - 1));
      bi = pc[13:2] & ((12'd1 << bb) - 1);
      ci = pc[13:2] & ((12'd1 << kb) - 1);
      gp = gsh_ctr[gi] >= 4;
      bp = bim_ctr[bi] >= 4;
      ug = chs_ctr[ci] >= 2;
      pr = ug ? gp : bp;
      if (ug) begin
        if (tk && gsh_ctr[gi] != CtrMax) gsh_ctr[gi]++;
        else if (!tk && gsh_ctr[gi] != 0) gsh_ctr[gi]--;
      end else begin
        if (tk && bim_ctr[bi] != CtrMax) bim_ctr[bi]++;
        else if (!tk && bim_ctr[bi] != 0) bim_ctr[bi]--;
      end
      ghist = (ghist >> 1) & ((12'd1 << (hb - 1)) - 1);
      if (tk) ghist = ghist | (12'd1 << (hb - 1));
      if (gp == tk && bp != tk) begin
        if (chs_ctr[ci] != ChsMax) chs_ctr[ci]++;
      end else if (gp != tk && bp == tk) begin
        if (chs_ctr[ci] != 0) chs_ctr[ci]--;
      end
      n_branch++;
      if (pr != tk) n_miss++;
      o.predicted_taken = pr;
      o.mispredicted = pr != tk;
      o.chose_gshare = ug;
      o.branch_count = n_branch;
      o.miss_count = n_miss;
      pending.push_back(o);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endfunction

    function void check_result(logic [OutDataW-1:0] raw);
      outcome_t g, w;
      g = raw[66:0];
      if (pending.size() == 0) begin
        report("unexpected item", raw[34:3], 0);
        return;
      end
      w = pending.pop_front();
      if (g.predicted_taken != w.predicted_taken)
        report("predicted_taken", g.predicted_taken, w.predicted_taken);
      if (g.mispredicted != w.mispredicted)
        report("mispredicted", g.mispredicted, w.mispredicted);
      if (g.chose_gshare != w.chose_gshare)
        report("chose_gshare", g.chose_gshare, w.chose_gshare);
      if (g.branch_count != w.branch_count)
        report("branch_count", g.branch_count, w.branch_count);
      if (g.miss_count != w.miss_count) report("miss_count", g.miss_count, w.miss_count);
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_valid_i = 0;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [3:0] cfg_data_i = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready_o;
  logic [OutDataW-1:0] m_axis_tdata;
  branch_scoreboard sb = new();
  int cycles = 0;
  int hot_pcs [8];

  tournament_branch_predictor_core dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls per item, with quiet stretches of none.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
    end
  end

  // Leaves tvalid high after the accept so a back-to-back item needs no gap.
  task automatic send_branch(logic [31:0] pc, logic tk, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'd0, tk, pc};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_branch(pc, tk);
  endtask

  task automatic write_width(logic [CfgIdxW-1:0] idx, logic [3:0] val);
    cfg_valid_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.width_reg[idx] = val;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    logic [3:0] w [4];
    logic [31:0] pc;
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: pc extremes, both outcomes, saturation on one hot branch.
    send_branch(32'h0, 0, 0);
    send_branch(32'hFFFF_FFFF, 1, 0);
    send_branch(32'hAAAA_AAAA, 1, 1);
    send_branch(32'h5555_5555, 0, 1);
    for (int i = 0; i < 10; i++) send_branch(32'h0000_1000, 1, 0);
    for (int i = 0; i < 10; i++) send_branch(32'h0000_1000, i[0], 1);
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: w = '{4'd12, 4'd12, 4'd12, 4'd12};
        1: w = '{4'd1, 4'd1, 4'd1, 4'd1};
        2: w = '{4'd0, 4'd15, 4'd15, 4'd0};
        3: w = '{4'd3, 4'd4, 4'd9, 4'd2};
        default: for (int k = 0; k < 4; k++) w[k] = 4'($urandom_range(0, 15));
      endcase
      for (int k = 0; k < 4; k++) write_width(CfgIdxW'(k), w[k]);
      cfg_valid_i <= 0;
      for (int k = 0; k < 8; k++) hot_pcs[k] = $urandom;
      for (int i = 0; i < 320; i++) begin
        // Mostly a small loop-like set of branches with biased outcomes.
        if ($urandom_range(0, 3) != 0) begin
          pc = hot_pcs[$urandom_range(0, 7)];
          send_branch(pc, ($urandom_range(0, 9) < (pc[4] ? 8 : 2)),
                      $urandom_range(0, 2) == 0);
        end else begin
          send_branch($urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
        end
      end
    end
    drain();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/tbp_pkg.sv
rtl/core/tbp_front.sv
rtl/core/tbp_back.sv
rtl/core/tournament_branch_predictor_core.sv
rtl/core/tbp_checker.sv
sim/tournament_branch_predictor_core_tb.sv
